FILE: hw/rtl/tdtt_pkg.sv
// Package for the task delay tick table: opcode and status codes, the
// delay counter width and the command struct broadcast to every slot cell.
// No dependencies.
`timescale 1ns / 1ps

package tdtt_pkg;

	localparam int DELAY_W = 16;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELAY  = 2'd1,
		OP_YIELD  = 2'd2,
		OP_TICK   = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_NOSLOT = 2'd2
	} status_t;

	// Command seen by all cells in the cycle an item is accepted.
	typedef struct packed {
		logic                fire;
		opcode_t             op;
		logic [DELAY_W-1:0]  ticks;
	} cell_cmd_t;

endpackage

FILE: hw/rtl/task_delay_tick_table_unit.sv
// Top level of the task delay tick table: a row of slot cells plus the
// task counter and the result register. Depends on tdtt_pkg and tdtt_cell.
`timescale 1ns / 1ps

// The unit keeps MAX_TASKS task slots, each a cell holding a created flag, a
// waiting flag and a 16-bit delay count. Every accepted item carries one
// operation (create, delay, yield or timer tick) and produces exactly one
// result item with the status, the id of a newly created task, the ready mask
// of slots 0 to 7 and the number of created tasks. The unit takes one item per
// clock cycle: all cells update in parallel in the cycle of acceptance, and
// the result appears in the output register on the following cycle. The
// input stays ready while the output register is empty or being drained, so a
// stalled consumer only stops the input once a result is waiting. Slots are
// created in order; each cell learns from its left neighbor whether it is the
// next free slot. Tasks beyond slot 7 cannot be addressed by delay or yield
// and do not show in the ready mask, and the id and count fields carry the
// low four bits of their values.
module task_delay_tick_table_unit #(
	parameter int MAX_TASKS = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] opcode,
	input  logic [2:0] task_index,
	input  logic [15:0] delay_ticks,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [1:0] status,
	output logic [3:0] new_task_id,
	output logic [7:0] ready_mask,
	output logic [3:0] task_total
);
	import tdtt_pkg::*;

	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int TW = (CW < 4) ? 4 : CW;

	cell_cmd_t            cmd;
	logic                 fire;
	opcode_t              op;
	logic [MAX_TASKS-1:0] created;
	logic [MAX_TASKS-1:0] ready_nx;
	logic [MAX_TASKS-1:0] hit;
	logic [7:0]           created_pad;
	logic [7:0]           ready_pad;
	logic [CW-1:0]        count_q;
	logic [CW-1:0]        count_nx;
	logic [TW-1:0]        count_ext;
	logic                 create_ok;
	status_t              status_d;
	logic                 out_valid_q;
	logic [1:0]           status_q;
	logic [3:0]           new_task_id_q;
	logic [7:0]           ready_mask_q;
	logic [3:0]           task_total_q;

	assign in_ready = !out_valid_q || out_ready;
	assign fire     = in_valid && in_ready;
	assign op       = opcode_t'(opcode);

	assign cmd.fire  = fire;
	assign cmd.op    = op;
	assign cmd.ticks = delay_ticks;

	// Row of slot cells; each passes its created flag to its right neighbor.
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		logic prev;
		if (i == 0) begin : g_first
			assign prev = 1'b1;
		end else begin : g_rest
			assign prev = created[i-1];
		end
		if (i < 8) begin : g_addr
			assign hit[i] = (task_index == 3'(i));
		end else begin : g_noaddr
			assign hit[i] = 1'b0;
		end
		tdtt_cell u_cell (
			.clk          (clk),
			.arst_n       (arst_n),
			.cmd          (cmd),
			.hit          (hit[i]),
			.prev_created (prev),
			.created      (created[i]),
			.ready_next   (ready_nx[i])
		);
	end

	// Only slots 0 to 7 are addressable and visible in the ready mask.
	assign created_pad = 8'(created);
	assign ready_pad   = 8'(ready_nx);

	// The table is full once the last cell is created.
	assign create_ok = fire && (op == OP_CREATE) && !created[MAX_TASKS-1];
	assign count_nx  = create_ok ? count_q + CW'(1) : count_q;
	assign count_ext = TW'(count_nx);

	always_comb begin
		status_d = ST_OK;
		unique case (op)
			OP_CREATE: begin
				if (created[MAX_TASKS-1]) begin
					status_d = ST_FULL;
				end
			end
			OP_DELAY, OP_YIELD: begin
				if (!created_pad[task_index]) begin
					status_d = ST_NOSLOT;
				end
			end
			OP_TICK: begin
				status_d = ST_OK;
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_nx;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q      <= status_d;
			new_task_id_q <= create_ok ? count_ext[3:0] : 4'd0;
			ready_mask_q  <= ready_pad;
			task_total_q  <= count_ext[3:0];
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign new_task_id = new_task_id_q;
	assign ready_mask  = ready_mask_q;
	assign task_total  = task_total_q;

	// Created slots always form a contiguous run starting at slot 0.
	a_thermometer: assert property (@(posedge clk) disable iff (!arst_n)
		(created & (created + MAX_TASKS'(1))) == '0)
		else $error("created slots are not contiguous");

	// The task counter tracks the number of created cells.
	a_count_match: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(created) == int'(count_q))
		else $error("task counter disagrees with created cells");

	// A successful create advances the counter by exactly one.
	a_create_step: assert property (@(posedge clk) disable iff (!arst_n)
		create_ok |=> count_q == $past(count_q) + CW'(1))
		else $error("create did not advance the task counter");

	// A pending result's task total matches the current task count.
	a_result_state: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (task_total_q == count_ext[3:0] || fire))
		else $error("task total does not match table state");

endmodule

FILE: hw/rtl/tdtt_cell.sv
// One task slot of the table: created flag, waiting flag and delay counter.
// Depends on tdtt_pkg; the created flag is handed on to the next cell.
`timescale 1ns / 1ps

module tdtt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  tdtt_pkg::cell_cmd_t cmd,
	input  logic               hit,
	input  logic               prev_created,
	output logic               created,
	output logic               ready_next
);
	import tdtt_pkg::*;

	logic               created_q;
	logic               waiting_q;
	logic [DELAY_W-1:0] delay_q;
	logic               created_next;
	logic               waiting_d;
	logic [DELAY_W-1:0] delay_d;
	logic [DELAY_W-1:0] delay_dec;

	assign delay_dec = (delay_q != '0) ? delay_q - DELAY_W'(1) : delay_q;

	always_comb begin
		created_next = created_q;
		waiting_d    = waiting_q;
		delay_d      = delay_q;
		if (cmd.fire) begin
			unique case (cmd.op)
				OP_CREATE: begin
					// A slot is created only directly behind the last created one.
					if (prev_created && !created_q) begin
						created_next = 1'b1;
						waiting_d    = 1'b0;
						delay_d      = '0;
					end
				end
				OP_DELAY: begin
					if (hit && created_q) begin
						waiting_d = 1'b1;
						delay_d   = cmd.ticks;
					end
				end
				OP_YIELD: begin
					if (hit && created_q) begin
						waiting_d = 1'b0;
					end
				end
				OP_TICK: begin
					if (created_q && waiting_q) begin
						delay_d = delay_dec;
						if (delay_dec == '0) begin
							waiting_d = 1'b0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign created    = created_q;
	assign ready_next = created_next && !waiting_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= 1'b0;
			waiting_q <= 1'b0;
			delay_q   <= '0;
		end else begin
			created_q <= created_next;
			waiting_q <= waiting_d;
			delay_q   <= delay_d;
		end
	end

endmodule
